>>> hw/rtl/n2ss_pkg.sv
`timescale 1ns / 1ps
package n2ss_pkg;

    // Binary input width and the number of BCD digits it needs (2^32 - 1 has 10)
    localparam int unsigned NUM_BITS    = 32;
    localparam int unsigned NUM_BCD     = 10;
    localparam int unsigned BCD_W       = 4 * NUM_BCD;
    localparam int unsigned NUM_SEGS    = 8;
    localparam int unsigned SEG_W       = 8;

    // Configuration register indexes
    localparam logic CFG_IDX_EIGHT_DIGIT_MODE = 1'b0;
    localparam logic CFG_IDX_SEG_ACTIVE_HIGH  = 1'b1;

    localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;
    localparam logic [SEG_W-1:0] SEG_BLANK = 8'h00;

    typedef logic [NUM_BITS-1:0] bin_t;
    typedef logic [BCD_W-1:0]    bcd_t;
    typedef logic [SEG_W-1:0]    seg_t;
    typedef seg_t                seg_row_t [NUM_SEGS];

    typedef struct packed {
        logic eight_digit_mode;
        logic seg_active_high;
    } cfg_t;

    // 0..9 font, bit0 = A ... bit6 = G
    function automatic seg_t seg_font(input logic [3:0] d);
        seg_t p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

    // Double-dabble correction: add 3 to each BCD digit of 5 or more
    function automatic bcd_t bcd_adjust(input bcd_t b);
        bcd_t r;
        for (int j = 0; j < NUM_BCD; j++) begin
            r[4*j +: 4] = (b[4*j +: 4] >= 4'd5) ? (b[4*j +: 4] + 4'd3) : b[4*j +: 4];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/n2ss_cell.sv
`timescale 1ns / 1ps
module n2ss_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  n2ss_pkg::bin_t  up_bin,
    input  n2ss_pkg::bcd_t  up_bcd,
    output logic            up_take,
    output logic            valid,
    output n2ss_pkg::bin_t  bin,
    output n2ss_pkg::bcd_t  bcd,
    input  logic            down_take
);
    import n2ss_pkg::*;

    logic valid_reg;
    bin_t bin_reg;
    bcd_t bcd_reg;
    bin_t bin_next;
    bcd_t bcd_next;
    bcd_t bcd_adj;

    // Cell can load when empty or when its word moves on this cycle
    assign up_take = !valid_reg || down_take;

    // One double-dabble step: correct digits, shift in the next binary bit
    always_comb
    begin
        bcd_adj  = bcd_adjust(up_bcd);
        bcd_next = {bcd_adj[BCD_W-2:0], up_bin[NUM_BITS-1]};
        bin_next = {up_bin[NUM_BITS-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_take)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_take)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign valid = valid_reg;
    assign bin   = bin_reg;
    assign bcd   = bcd_reg;

endmodule

>>> hw/rtl/n2ss_decode.sv
`timescale 1ns / 1ps
module n2ss_decode (
    input  n2ss_pkg::bcd_t     bcd,
    input  n2ss_pkg::cfg_t     cfg,
    output n2ss_pkg::seg_row_t segs,
    output logic               overflow
);
    import n2ss_pkg::*;

    logic [2:0]  range_sel;
    logic [15:0] win;
    seg_t        pat [NUM_SEGS];

    always_comb
    begin
        // Auto-range: drop up to four low digits while the value has more than four
        if (|bcd[BCD_W-1:28])
            range_sel = 3'd4;
        else if (|bcd[BCD_W-1:24])
            range_sel = 3'd3;
        else if (|bcd[BCD_W-1:20])
            range_sel = 3'd2;
        else if (|bcd[BCD_W-1:16])
            range_sel = 3'd1;
        else
            range_sel = 3'd0;

        case (range_sel)
            3'd0:    win = bcd[15:0];
            3'd1:    win = bcd[19:4];
            3'd2:    win = bcd[23:8];
            3'd3:    win = bcd[27:12];
            3'd4:    win = bcd[31:16];
            default: win = bcd[15:0];
        endcase

        for (int m = 0; m < NUM_SEGS; m++) begin
            if (cfg.eight_digit_mode)
            begin
                pat[m] = seg_font(bcd[4*(NUM_SEGS-1-m) +: 4]);
            end
            else if (m < 4)
            begin
                pat[m] = seg_font(win[4*(3-m) +: 4]);
                if ({1'b0, range_sel} == 4'(m + 1))
                    pat[m] = pat[m] | SEG_DP;
            end
            else
            begin
                pat[m] = SEG_BLANK;
            end
            segs[m] = cfg.seg_active_high ? pat[m] : ~pat[m];
        end

        overflow = |bcd[BCD_W-1:32];
    end

endmodule

>>> hw/rtl/number_to_seven_segment_core.sv
`timescale 1ns / 1ps
// Binary to 7-segment display encoder.
// Input channel: in_valid / in_ready carry one 32-bit unsigned value per word.
// Output channel: out_valid / out_ready carry eight segment patterns
// (digit0 leftmost, bit0 = A .. bit6 = G, bit7 = dot) plus an overflow flag
// that is set when the value exceeds 99,999,999.
// Config port: cfg_write_en writes cfg_data[0] to register cfg_index at the
// clock edge (0 = eight_digit_mode, 1 = seg_active_high). Write only while idle.
// An accepted word passes through the 32-cell double-dabble chain (one
// binary bit per cell) and then the output register.
// Throughput: one word per cycle while out_ready holds; a new word can enter every cycle until the chain fills.
// Each cell loads whenever it is empty or its word moves on, so when the
// receiver stalls the chain keeps compacting and in_ready only drops once
// every cell and the output register are full. A stalled output word holds.
// Reset: all valid bits clear, eight_digit_mode = 0, seg_active_high = 1.
module number_to_seven_segment_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  digit0,
    output logic [7:0]  digit1,
    output logic [7:0]  digit2,
    output logic [7:0]  digit3,
    output logic [7:0]  digit4,
    output logic [7:0]  digit5,
    output logic [7:0]  digit6,
    output logic [7:0]  digit7,
    output logic        overflow
);
    import n2ss_pkg::*;

    cfg_t     cfg_reg;
    logic     out_valid_reg;
    seg_row_t segs_reg;
    logic     overflow_reg;

    // Chain taps: index 0 is the input side, NUM_BITS the last cell
    logic     valid_c [NUM_BITS+1];
    bin_t     bin_c   [NUM_BITS+1];
    bcd_t     bcd_c   [NUM_BITS+1];
    logic     take_c  [NUM_BITS+1];

    seg_row_t segs_dec;
    logic     overflow_dec;
    logic     out_take;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eight_digit_mode <= 1'b0;
            cfg_reg.seg_active_high  <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IDX_EIGHT_DIGIT_MODE: cfg_reg.eight_digit_mode <= cfg_data;
                CFG_IDX_SEG_ACTIVE_HIGH:  cfg_reg.seg_active_high  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign valid_c[0] = in_valid;
    assign bin_c[0]   = value;
    assign bcd_c[0]   = '0;
    assign in_ready   = take_c[0];

    // Double-dabble chain, one cell per input bit
    for (genvar i = 0; i < NUM_BITS; i++) begin : g_cell
        n2ss_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .up_valid  (valid_c[i]),
            .up_bin    (bin_c[i]),
            .up_bcd    (bcd_c[i]),
            .up_take   (take_c[i]),
            .valid     (valid_c[i+1]),
            .bin       (bin_c[i+1]),
            .bcd       (bcd_c[i+1]),
            .down_take (take_c[i+1])
        );
    end

    // Segment decode of the finished BCD word
    n2ss_decode u_decode (
        .bcd      (bcd_c[NUM_BITS]),
        .cfg      (cfg_reg),
        .segs     (segs_dec),
        .overflow (overflow_dec)
    );

    // Output register: loads when empty or when the receiver takes the word
    assign out_take         = !out_valid_reg || out_ready;
    assign take_c[NUM_BITS] = out_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= valid_c[NUM_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            segs_reg     <= segs_dec;
            overflow_reg <= overflow_dec;
        end
    end

    assign out_valid = out_valid_reg;
    assign digit0    = segs_reg[0];
    assign digit1    = segs_reg[1];
    assign digit2    = segs_reg[2];
    assign digit3    = segs_reg[3];
    assign digit4    = segs_reg[4];
    assign digit5    = segs_reg[5];
    assign digit6    = segs_reg[6];
    assign digit7    = segs_reg[7];
    assign overflow  = overflow_reg;

endmodule

>>> hw/rtl/n2ss_checker.sv
`timescale 1ns / 1ps
module n2ss_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  digit0,
    input  logic [7:0]  digit1,
    input  logic [7:0]  digit2,
    input  logic [7:0]  digit3,
    input  logic [7:0]  digit4,
    input  logic [7:0]  digit5,
    input  logic [7:0]  digit6,
    input  logic [7:0]  digit7,
    input  logic        overflow
);
    import n2ss_pkg::*;

    cfg_t       cfg_reg;
    logic [7:0] blank;
    logic [3:0] dots;

    // Shadow of the config registers, tracked from the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.eight_digit_mode <= 1'b0;
            cfg_reg.seg_active_high  <= 1'b1;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IDX_EIGHT_DIGIT_MODE: cfg_reg.eight_digit_mode <= cfg_data;
                CFG_IDX_SEG_ACTIVE_HIGH:  cfg_reg.seg_active_high  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign blank = cfg_reg.seg_active_high ? SEG_BLANK : ~SEG_BLANK;
    assign dots  = {digit3[7], digit2[7], digit1[7], digit0[7]}
                 ^ {4{!cfg_reg.seg_active_high}};

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit0) && $stable(digit3)
            && $stable(digit7) && $stable(overflow))
        else $error("output word changed while stalled");

    a_four_blank: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_reg.eight_digit_mode |->
            digit4 == blank && digit5 == blank && digit6 == blank && digit7 == blank)
        else $error("unused digits not blank in four-digit mode");

    a_eight_no_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cfg_reg.eight_digit_mode |->
            (dots == 4'b0000) && (digit7[7] == !cfg_reg.seg_active_high))
        else $error("dot lit in eight-digit mode");

    a_one_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_reg.eight_digit_mode |-> $onehot0(dots))
        else $error("more than one dot lit");

    a_ovf_dot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cfg_reg.eight_digit_mode && overflow |-> dots == 4'b1000)
        else $error("overflow without dot on digit3");

endmodule

bind number_to_seven_segment_core n2ss_checker u_n2ss_checker (.*);

>>> test/tb_number_to_seven_segment_core.sv
`timescale 1ns / 1ps
module tb_number_to_seven_segment_core;
    import n2ss_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;    // longer than the 33-word pipeline depth
    localparam int unsigned DRAIN_WAIT  = 40;    // extra wait after the last output word

    // One displayed result: eight segment patterns and the overflow flag
    typedef struct packed {
        seg_t [7:0] seg;
        logic       ovf;
    } panel_t;

    // 0..9 glyphs, bit0 = A .. bit6 = G
    localparam seg_t GLYPH [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                    8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic        cfg_index;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  digit0, digit1, digit2, digit3;
    logic [7:0]  digit4, digit5, digit6, digit7;
    logic        overflow;

    // Words waiting to be offered, and panels the block still owes us
    bit [31:0] pending_values [$];
    panel_t    awaited_panels [$];

    // Our copy of the configuration registers
    bit mode_eight;
    bit mode_cathode;

    bit          calm;          // no idling on either side while set
    int unsigned burst_req;     // bumped to ask the receiver for a long hold-off
    int unsigned burst_seen;
    int unsigned hold_left;
    int unsigned errors;
    int unsigned cycles;

    number_to_seven_segment_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digit0       (digit0),
        .digit1       (digit1),
        .digit2       (digit2),
        .digit3       (digit3),
        .digit4       (digit4),
        .digit5       (digit5),
        .digit6       (digit6),
        .digit7       (digit7),
        .overflow     (overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // What the display should show for v under the given configuration.
    // Four-digit mode auto-ranges the value onto digits 0..3 and marks the
    // scale with a dot; eight-digit mode shows the low eight decimal digits.
    function automatic panel_t display_for(bit [31:0] v, bit eight, bit cathode);
        panel_t      p;
        int unsigned n;
        int unsigned dot;
        seg_t        pat;
        p.ovf = (v > 32'd99999999);
        n     = v;
        dot   = 0;
        if (eight)
        begin
            for (int k = 7; k >= 0; k--)
            begin
                pat      = GLYPH[n % 10];
                p.seg[k] = cathode ? pat : ~pat;
                n        = n / 10;
            end
        end
        else
        begin
            if (n > 9999999)
            begin
                n   = n / 10000;
                dot = 4;
            end
            else if (n > 999999)
            begin
                n   = n / 1000;
                dot = 3;
            end
            else if (n > 99999)
            begin
                n   = n / 100;
                dot = 2;
            end
            else if (n > 9999)
            begin
                n   = n / 10;
                dot = 1;
            end
            // quotient may still exceed 9999 on overflow: low four digits only
            for (int k = 3; k >= 0; k--)
            begin
                pat = GLYPH[n % 10];
                if (dot == k + 1)
                    pat = pat | SEG_DP;
                p.seg[k] = cathode ? pat : ~pat;
                n        = n / 10;
            end
            for (int k = 4; k < 8; k++)
                p.seg[k] = cathode ? SEG_BLANK : ~SEG_BLANK;
        end
        return p;
    endfunction

    // Sender: valid holds with a stable word until accepted. The expected
    // panel is computed at the accepting edge from the current config copy.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                awaited_panels.push_back(display_for(value, mode_eight, mode_cathode));
            if (!in_valid || in_ready)
            begin
                if (pending_values.size() != 0 && (calm || $urandom_range(99) >= 11))
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so that the
    // pipeline fills up and in_ready drops.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            hold_left  <= 0;
            burst_seen <= 0;
        end
        else if (burst_req != burst_seen)
        begin
            burst_seen <= burst_req;
            hold_left  <= HOLD_CYCLES;
            out_ready  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= calm || ($urandom_range(99) >= 11);
    end

    // Checker: every accepted output word against the oldest awaited panel
    always @(posedge clk)
    begin
        panel_t got;
        panel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got.seg = {digit7, digit6, digit5, digit4, digit3, digit2, digit1, digit0};
            got.ovf = overflow;
            if (awaited_panels.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output word, digits %h overflow %b",
                         $time, got.seg, got.ovf);
            end
            else
            begin
                want = awaited_panels.pop_front();
                for (int k = 0; k < 8; k++)
                begin
                    if (got.seg[k] !== want.seg[k])
                    begin
                        errors++;
                        $display("%0t: digit%0d expected %h actual %h",
                                 $time, k, want.seg[k], got.seg[k]);
                    end
                end
                if (got.ovf !== want.ovf)
                begin
                    errors++;
                    $display("%0t: overflow expected %b actual %b",
                             $time, want.ovf, got.ovf);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("number_to_seven_segment_core regression: fail");
            $finish;
        end
    end

    // Idle means nothing queued, nothing offered and nothing owed
    task automatic wait_drained();
        @(posedge clk);
        while (pending_values.size() != 0 || in_valid || awaited_panels.size() != 0)
            @(posedge clk);
    endtask

    // Config writes only while the block is idle; both registers every time
    task automatic set_display_mode(bit eight, bit cathode);
        wait_drained();
        cfg_write_en <= 1'b1;
        cfg_index    <= CFG_IDX_EIGHT_DIGIT_MODE;
        cfg_data     <= eight;
        @(posedge clk);
        cfg_index    <= CFG_IDX_SEG_ACTIVE_HIGH;
        cfg_data     <= cathode;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        mode_eight   = eight;
        mode_cathode = cathode;
    endtask

    initial
    begin
        bit [31:0] corners [20];
        bit [31:0] edges [7];
        bit [1:0]  settings [8];
        bit [31:0] v;

        // range boundaries, overflow edge, all-ones and alternating bits
        corners = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd9999, 32'd10000,
                    32'd99999, 32'd100000, 32'd999999, 32'd1000000,
                    32'd9999999, 32'd10000000, 32'd12345678, 32'd99999999,
                    32'd100000000, 32'd987654321, 32'hAAAAAAAA, 32'h55555555,
                    32'hFFFFFFFE, 32'hFFFFFFFF};
        edges    = '{32'd0, 32'd9999, 32'd99999, 32'd999999, 32'd9999999,
                     32'd99999999, 32'hFFFFFFFF};
        // {eight_digit_mode, seg_active_high} per random phase
        settings = '{2'b01, 2'b11, 2'b00, 2'b10, 2'b11, 2'b01, 2'b10, 2'b00};

        errors       = 0;
        cycles       = 0;
        calm         = 1'b0;
        burst_req    = 0;
        mode_eight   = 1'b0;   // reset values
        mode_cathode = 1'b1;
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= CFG_IDX_EIGHT_DIGIT_MODE;
        cfg_data     <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed words under the reset configuration
        foreach (corners[i])
            pending_values.push_back(corners[i]);

        foreach (settings[ph])
        begin
            set_display_mode(settings[ph][1], settings[ph][0]);
            calm = (ph == 2);
            // long receiver hold-off while the sender keeps offering
            if (ph == 1 || ph == 5)
                burst_req++;
            repeat (50)
            begin
                case ($urandom_range(3))
                    0: v = $urandom;
                    1: v = $urandom >> $urandom_range(31);
                    2: v = edges[$urandom_range(6)] + $urandom_range(6) - 3;
                    default: v = $urandom_range(99999);
                endcase
                pending_values.push_back(v);
            end
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("number_to_seven_segment_core regression: pass");
        else
            $display("number_to_seven_segment_core regression: fail");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/n2ss_pkg.sv
hw/rtl/n2ss_cell.sv
hw/rtl/n2ss_decode.sv
hw/rtl/number_to_seven_segment_core.sv
hw/rtl/n2ss_checker.sv
test/tb_number_to_seven_segment_core.sv
